@@ design/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Depends on nothing; imported by sha256_byte_stream_hash_top.

package sha256_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL_ADD,
      ST_PAD,
      ST_OUTPUT
   } state_type;

   typedef logic [31:0] word_type;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned SCHED_DEPTH = 16;
   localparam int unsigned HASH_WORDS = 8;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam word_type INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Round and schedule mixing functions
   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

@@ design/sha256_byte_stream_hash_top.sv @@
// SHA-256 hasher over a byte stream: byte packing, padding, round sequencer, digest output.
// Depends on sha256_pkg.
//
// Usage:
//   req_ channel carries one transaction per message byte (req_has_byte) and marks the
//   end of a message with req_end_message; an end transaction may carry no byte, which
//   hashes the empty message. rsp_ channel returns the digest as eight 32-bit words,
//   word 0 (most significant) first, rsp_last_word set on word 7.
// Timing:
//   A byte that does not complete a 64-byte block is taken without raising req_stall. A byte that
//   completes a block holds req_stall high while the 64 rounds run on the single
//   round unit and the working words are then folded into the chaining value.
//   After an end transaction the block inserts the padding one byte per cycle through
//   the same byte path (up to 72 bytes when the length spills into an extra block),
//   pausing while a block is compressed; it runs one or two compressions, then
//   presents the eight digest words, one per cycle while rsp_stall is low.
// Reset and stall:
//   Synchronous reset loads the initial hash words and clears the byte and bit counts.
//   req_stall is high whenever a block is being compressed, padding is inserted or a
//   digest is pending; a high rsp_stall holds the current digest word unchanged.
//   After word 7 is taken the block starts a new message from the initial hash.

module sha256_byte_stream_hash_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_has_byte,
   input  logic                  req_end_message,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sha256_pkg::word_type  rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word
);

   import sha256_pkg::*;

   // Control state
   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    word_idx_ff, word_idx_in;
   logic [63:0]   bit_count_ff, bit_count_in;
   logic          pad_active_ff, pad_active_in;
   logic          pad_first_ff, pad_first_in;
   logic          len_ok_ff, len_ok_in;
   logic          final_ff, final_in;
   word_type      chain_ff [HASH_WORDS];
   word_type      chain_in [HASH_WORDS];

   // Datapath state
   logic [23:0]   part_ff, part_in;
   word_type      sched_ff [SCHED_DEPTH];
   word_type      sched_in [SCHED_DEPTH];
   word_type      var_ff [HASH_WORDS];
   word_type      var_in [HASH_WORDS];

   logic          req_accept;
   logic          rsp_accept;
   logic          push_en;
   logic [7:0]    push_byte;
   logic          is_len_byte;
   word_type      t1, t2, w_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_OUTPUT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign rsp_digest_word = chain_ff[word_idx_ff];
   assign rsp_word_index  = word_idx_ff;
   assign rsp_last_word   = (word_idx_ff == LAST_WORD_IDX);

   // Round unit: one SHA-256 round and one schedule word per cycle
   always_comb begin
      t1 = var_ff[7] + big_sigma1(var_ff[4])
         + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
         + ROUND_K[round_ff] + sched_ff[0];
      t2 = big_sigma0(var_ff[0])
         + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
      w_next = small_sigma1(sched_ff[14]) + sched_ff[9] + small_sigma0(sched_ff[1])
             + sched_ff[0];
   end

   // Padding byte: marker first, then zeros, then the bit count big-endian
   assign is_len_byte = !pad_first_ff && len_ok_ff && (fill_ff >= LEN_POS);

   // Sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      round_in      = round_ff;
      word_idx_in   = word_idx_ff;
      bit_count_in  = bit_count_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      len_ok_in     = len_ok_ff;
      final_in      = final_ff;
      part_in       = part_ff;
      chain_in      = chain_ff;
      sched_in      = sched_ff;
      var_in        = var_ff;
      push_en       = 1'b0;
      push_byte     = req_data_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               push_en = req_has_byte;
               if (req_has_byte) begin
                  bit_count_in = bit_count_ff + BITS_PER_BYTE;
               end
               if (req_end_message) begin
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
                  len_ok_in     = 1'b0;
                  state_in      = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (pad_first_ff) begin
               push_byte = PAD_MARK;
            end else if (is_len_byte) begin
               push_byte = bit_count_ff[63:56];
            end else begin
               push_byte = 8'h00;
            end
            // advance the length byte window
            if (is_len_byte) begin
               bit_count_in = {bit_count_ff[55:0], 8'h00};
            end
            pad_first_in = 1'b0;
            if (pad_first_ff && (fill_ff < LEN_POS)) begin
               len_ok_in = 1'b1;
            end
         end
         ST_ROUND: begin
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[SCHED_DEPTH - 1] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_POS) begin
               state_in = ST_FINAL_ADD;
            end
         end
         ST_FINAL_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + var_ff[i];
            end
            if (final_ff) begin
               word_idx_in = '0;
               state_in    = ST_OUTPUT;
            end else if (pad_active_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            if (rsp_accept) begin
               word_idx_in = word_idx_ff + 3'd1;
               if (word_idx_ff == LAST_WORD_IDX) begin
                  // restart from the initial hash for the next message
                  chain_in      = INIT_HASH;
                  bit_count_in  = '0;
                  fill_in       = '0;
                  pad_active_in = 1'b0;
                  final_in      = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
      endcase

      // Byte path: pack bytes into words, shift words into the schedule line
      if (push_en) begin
         part_in = {part_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < SCHED_DEPTH - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[SCHED_DEPTH - 1] = {part_ff, push_byte};
         end
         // full block: start compression
         if (fill_ff == LAST_POS) begin
            var_in   = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
            if (state_ff == ST_PAD) begin
               final_in  = len_ok_ff;
               len_ok_in = 1'b1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         round_ff      <= '0;
         word_idx_ff   <= '0;
         bit_count_ff  <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_ok_ff     <= 1'b0;
         final_ff      <= 1'b0;
         chain_ff      <= INIT_HASH;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         round_ff      <= round_in;
         word_idx_ff   <= word_idx_in;
         bit_count_ff  <= bit_count_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         len_ok_ff     <= len_ok_in;
         final_ff      <= final_in;
         chain_ff      <= chain_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      part_ff  <= part_in;
      sched_ff <= sched_in;
      var_ff   <= var_in;
   end

`ifndef NO_ASSERTIONS
   // No new transaction while a digest is pending
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while digest pending");

   // Compression always starts on a block boundary
   a_round_start_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd0) |-> (fill_ff == 6'd0))
      else $error("compression started with partial block");

   // Round counter rests at zero outside the round loop
   a_round_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (round_ff == 6'd0))
      else $error("round counter not at zero outside rounds");

   // Last digest word returns the chaining value to the initial hash
   a_restart_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_word) |=>
         (chain_ff[0] == INIT_HASH[0] && fill_ff == 6'd0 && bit_count_ff == 64'd0))
      else $error("state not restarted after digest");
`endif

endmodule
